@@ rtl/smt_pkg.sv @@
`default_nettype none

package smt_pkg;

    // request modes
    localparam logic [2:0] MODE_INS_UNIQUE = 3'd0;
    localparam logic [2:0] MODE_INS_REPEAT = 3'd1;
    localparam logic [2:0] MODE_POP        = 3'd2;
    localparam logic [2:0] MODE_DELETE     = 3'd3;
    localparam logic [2:0] MODE_MEMBER     = 3'd4;
    localparam logic [2:0] MODE_COUNT      = 3'd5;

    // result status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_DUP       = 3'd1;
    localparam logic [2:0] STAT_EMPTY     = 3'd2;
    localparam logic [2:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [2:0] STAT_FULL      = 3'd4;

    // external field widths
    localparam int MODE_W  = 3;
    localparam int KEY_W   = 16;
    localparam int COUNT_W = 7;

    typedef logic [COUNT_W-1:0] count_t;

endpackage

`default_nettype wire

@@ rtl/sorted_multiset_table_unit.sv @@
`default_nettype none

// channel  | valid     | stall     | payload
// ---------+-----------+-----------+-------------------------------------------------
// request  | in_valid  | in_stall  | mode, key
// result   | out_valid | out_stall | status, popped_key, is_member, occurrences,
//          |           |           | table_size
//
// a request holds the unit from accept to the next accept: the accept, one read per stored
// entry, the ram's registered read, a check that sees the read pipe empty and the settling
// of the result in S_FIN
// the insert or delete shift rides along the same pass on the ram's write port
// reset clears the fill count and the control state; the ram itself is never cleared
// a stalled result holds in its register, and the next request waits only at its final cycle

module sorted_multiset_table_unit
    import smt_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [MODE_W-1:0]  mode,
    input  wire logic [KEY_W-1:0]   key,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [2:0]              status,
    output logic [KEY_W-1:0]        popped_key,
    output logic                    is_member,
    output count_t                  occurrences,
    output count_t                  table_size
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    // clamp a count to the 7-bit result field
    function automatic count_t sat7(input logic [CNT_W-1:0] v);
        sat7 = (32'(v) > 32'd127) ? count_t'(127) : count_t'(v);
    endfunction

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;    // reads issued so far
    logic                d_vld_reg, d_vld_next;      // ram read data valid
    logic [IDX_W-1:0]    d_idx_reg, d_idx_next;      // index of the entry on ram_rdata
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [CNT_W-1:0]    fill_reg, fill_next;
    logic [CNT_W-1:0]    occ_reg, occ_next;
    logic                ins_act_reg, ins_act_next;  // shifting right after insert point
    logic                del_act_reg, del_act_next;  // shifting left after removed entry
    logic [KEY_BITS-1:0] carry_reg, carry_next;      // entry displaced by the insert
    logic [KEY_BITS-1:0] pop_key_reg, pop_key_next;

    logic                out_valid_reg, out_valid_next;
    logic [2:0]          status_reg, status_next;
    logic [KEY_W-1:0]    popped_reg, popped_next;
    logic                member_reg, member_next;
    count_t              occ_out_reg, occ_out_next;
    count_t              size_reg, size_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [KEY_BITS-1:0] ram_wdata;
    logic [IDX_W-1:0]    ram_raddr;
    logic [KEY_BITS-1:0] ram_rdata;

    logic                accept;
    logic                load_ok;
    logic                is_ins;
    logic                full;
    logic                ins_ok;
    logic                ent_lt;
    logic                ent_eq;
    logic                ent_gt;
    logic [2:0]          fin_status;
    logic [CNT_W-1:0]    fin_occ;

    smt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign accept      = in_valid && !in_stall;
    assign load_ok     = !out_valid_reg || !out_stall;

    assign is_ins      = (mode_reg == MODE_INS_UNIQUE) || (mode_reg == MODE_INS_REPEAT);
    assign full        = (fill_reg == CNT_W'(CAPACITY));
    // all equal keys precede the first larger one, so the count is complete here
    assign ins_ok      = is_ins && !full
                         && ((mode_reg == MODE_INS_REPEAT) || (occ_reg == '0));

    // the one shared comparator against the request key
    assign ent_lt      = ram_rdata < key_reg;
    assign ent_eq      = ram_rdata == key_reg;
    assign ent_gt      = !ent_lt && !ent_eq;

    assign ram_raddr   = rd_cnt_reg[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        rd_cnt_next    = rd_cnt_reg;
        d_vld_next     = 1'b0;
        d_idx_next     = d_idx_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        occ_next       = occ_reg;
        ins_act_next   = ins_act_reg;
        del_act_next   = del_act_reg;
        carry_next     = carry_reg;
        pop_key_next   = pop_key_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        popped_next    = popped_reg;
        member_next    = member_reg;
        occ_out_next   = occ_out_reg;
        size_next      = size_reg;
        ram_we         = 1'b0;
        ram_waddr      = d_idx_reg;
        ram_wdata      = carry_reg;
        fin_status     = STAT_OK;
        fin_occ        = occ_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mode_next    = mode;
                    key_next     = KEY_BITS'(key);
                    rd_cnt_next  = '0;
                    occ_next     = '0;
                    ins_act_next = 1'b0;
                    del_act_next = 1'b0;
                    pop_key_next = '0;
                    state_next   = S_SCAN;
                end
            end

            S_SCAN:
            begin
                // issue the next read
                if (rd_cnt_reg < fill_reg)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                    d_vld_next  = 1'b1;
                    d_idx_next  = rd_cnt_reg[IDX_W-1:0];
                end
                else if (!d_vld_reg)
                begin
                    state_next = S_FIN;
                end

                // work on the entry that came back
                if (d_vld_reg)
                begin
                    occ_next = occ_reg + CNT_W'(ent_eq);
                    unique case (mode_reg) inside
                        MODE_INS_UNIQUE, MODE_INS_REPEAT:
                        begin
                            if (ins_act_reg)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = d_idx_reg;
                                ram_wdata  = carry_reg;
                                carry_next = ram_rdata;
                            end
                            else if (ent_gt && ins_ok)
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = d_idx_reg;
                                ram_wdata    = key_reg;
                                carry_next   = ram_rdata;
                                ins_act_next = 1'b1;
                            end
                        end
                        MODE_POP, MODE_DELETE:
                        begin
                            if (del_act_reg)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = d_idx_reg - 1'b1;
                                ram_wdata = ram_rdata;
                            end
                            else if ((mode_reg == MODE_DELETE && ent_eq)
                                     || (mode_reg == MODE_POP && d_idx_reg == '0))
                            begin
                                del_act_next = 1'b1;
                            end
                            if (mode_reg == MODE_POP && d_idx_reg == '0)
                            begin
                                pop_key_next = ram_rdata;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FIN:
            begin
                if (load_ok)
                begin
                    unique case (mode_reg) inside
                        MODE_INS_UNIQUE, MODE_INS_REPEAT:
                        begin
                            if (mode_reg == MODE_INS_UNIQUE && occ_reg != '0)
                            begin
                                fin_status = STAT_DUP;
                            end
                            else if (full)
                            begin
                                fin_status = STAT_FULL;
                            end
                            else
                            begin
                                // tail write: displaced entry, or the key when it is largest
                                ram_we    = 1'b1;
                                ram_waddr = fill_reg[IDX_W-1:0];
                                ram_wdata = ins_act_reg ? carry_reg : key_reg;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        MODE_POP:
                        begin
                            fin_occ = '0;
                            if (fill_reg == '0)
                            begin
                                fin_status = STAT_EMPTY;
                            end
                            else
                            begin
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (occ_reg == '0)
                            begin
                                fin_status = STAT_NOT_FOUND;
                            end
                            else
                            begin
                                fill_next = fill_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    out_valid_next = 1'b1;
                    status_next    = fin_status;
                    popped_next    = (mode_reg == MODE_POP) ? KEY_W'(pop_key_reg) : '0;
                    member_next    = (fin_occ != '0);
                    occ_out_next   = sat7(fin_occ);
                    size_next      = sat7(fill_next);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            d_vld_reg     <= 1'b0;
            fill_reg      <= '0;
            ins_act_reg   <= 1'b0;
            del_act_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            d_vld_reg     <= d_vld_next;
            fill_reg      <= fill_next;
            ins_act_reg   <= ins_act_next;
            del_act_reg   <= del_act_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_idx_reg   <= d_idx_next;
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        occ_reg     <= occ_next;
        carry_reg   <= carry_next;
        pop_key_reg <= pop_key_next;
        status_reg  <= status_next;
        popped_reg  <= popped_next;
        member_reg  <= member_next;
        occ_out_reg <= occ_out_next;
        size_reg    <= size_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign popped_key  = popped_reg;
    assign is_member   = member_reg;
    assign occurrences = occ_out_reg;
    assign table_size  = size_reg;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= CAPACITY)
        else $error("fill count above capacity");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == S_SCAN)
        else $error("accepted request did not start a scan");

    a_fill_fin_only: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_FIN |=> $stable(fill_reg))
        else $error("fill count changed outside the final cycle");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> 32'(ram_waddr) < CAPACITY)
        else $error("ram write beyond capacity");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the final cycle");
`endif

endmodule

`default_nettype wire

@@ rtl/smt_ram.sv @@
`default_nettype none

module smt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire
